@@ src/xfd_pkg.sv @@
`timescale 1ns / 1ps

package xfd_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 512;
  localparam int BYTE_W              = 8;
  localparam int LEN_W               = 16;
  localparam int CFG_W               = 9;
  localparam logic [CFG_W-1:0] EXP_LEN_RST = 9'd64;
  localparam logic [BYTE_W-1:0] STATUS_BAD = 8'hFF;

  typedef enum logic [2:0] {
    PH_LEN_HI = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_DATA   = 3'd2,
    PH_STATUS = 3'd3,
    PH_CHECK  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    FC_OK        = 2'd0,
    FC_CSUM_BAD  = 2'd1,
    FC_MALFORMED = 2'd2
  } frame_code_t;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

endpackage

@@ src/xor_frame_decoder_unit.sv @@
`timescale 1ns / 1ps

// Frame deframer for a byte stream: each frame is a big-endian 16-bit length L,
// then L-1 data bytes, one status byte and an XOR checksum of every byte before
// it. Data bytes come out one item each as they arrive (tuser = 0); the checksum
// byte yields one end-of-frame verdict item (tuser = 1, tlast = 1) carrying the
// status byte, a frame code (ok, checksum mismatch, malformed length) and a flag
// telling whether L-1 equals cfg expected_data_len. A length of 0, or one with
// L + 3 above MAX_FRAME_BYTES, ends the frame at once with a malformed verdict.
// Length bytes of a legal length and the status byte produce no item. Throughput
// is one byte per clock while out_tready does not stall the output: every byte
// passes a running XOR and a down counter into a single output register, and a
// new byte is taken whenever that register is empty or being drained.
// On a verdict other than ok, discard the data bytes of that frame.
module xor_frame_decoder_unit import xfd_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration write: expected_data_len
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] rx_byte
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata,  // [7:0] out_byte, [9:8] frame_code,
                                       // [17:10] status_byte, [18] length_match,
                                       // [23:19] zero
  output logic             out_tuser,  // [0] kind
  output logic             out_tlast   // is_last
);

  // counter width: largest legal L-1 is MAX_FRAME_BYTES-4
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_FRAME_BYTES - 3);

  // ---------------------------------------------------------------- state
  phase_t             phase_r, phase_nxt;
  logic [BYTE_W-1:0]  len_hi_r, len_hi_nxt;
  logic [CNT_W-1:0]   len_m1_r, len_m1_nxt;
  logic [CNT_W-1:0]   left_r, left_nxt;
  logic [BYTE_W-1:0]  xor_r, xor_nxt;
  logic [BYTE_W-1:0]  status_r, status_nxt;
  logic [CFG_W-1:0]   exp_len_r;

  // output register
  logic               ov_r;
  logic [BYTE_W-1:0]  o_byte_r;
  frame_code_t        o_code_r;
  logic [BYTE_W-1:0]  o_status_r;
  logic               o_match_r;
  logic               o_kind_r;
  logic               o_last_r;

  // result of the current byte
  logic               res_vld;
  logic [BYTE_W-1:0]  res_byte;
  frame_code_t        res_code;
  logic [BYTE_W-1:0]  res_status;
  logic               res_match;
  logic               res_kind;
  logic               res_last;

  logic               in_acc;
  logic [BYTE_W-1:0]  rx;
  logic [LEN_W-1:0]   frame_len;
  logic [LEN_W-1:0]   frame_len_m1;
  logic               len_bad;
  logic               len_match;

  assign cfg_ready = 1'b1;
  // take a byte when the output slot is free or draining this cycle
  assign in_tready = !ov_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign rx        = in_tdata;

  assign frame_len    = {len_hi_r, rx};
  assign frame_len_m1 = frame_len - LEN_W'(1);
  assign len_bad      = (frame_len == '0) || (frame_len > LEN_LIMIT);
  assign len_match    = (CMP_W'(len_m1_r) == CMP_W'(exp_len_r));

  // ---------------------------------------------------------------- next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc) begin
      case (phase_r)
        PH_LEN_LO: begin
          if (len_bad) begin
            phase_nxt = PH_LEN_HI;
          end else if (frame_len_m1 == '0) begin
            phase_nxt = PH_STATUS;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          if (left_r == CNT_W'(1)) begin
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: phase_nxt = PH_CHECK;
        PH_CHECK:  phase_nxt = PH_LEN_HI;
        default:   phase_nxt = PH_LEN_LO;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    len_hi_nxt = len_hi_r;
    len_m1_nxt = len_m1_r;
    left_nxt   = left_r;
    xor_nxt    = xor_r;
    status_nxt = status_r;
    if (in_acc) begin
      case (phase_r)
        PH_LEN_LO: begin
          xor_nxt = xor_r ^ rx;
          if (!len_bad) begin
            len_m1_nxt = frame_len_m1[CNT_W-1:0];
            left_nxt   = frame_len_m1[CNT_W-1:0];
          end
        end
        PH_DATA: begin
          xor_nxt  = xor_r ^ rx;
          left_nxt = left_r - CNT_W'(1);
        end
        PH_STATUS: begin
          xor_nxt    = xor_r ^ rx;
          status_nxt = rx;
        end
        PH_CHECK: xor_nxt = '0;
        default: begin
          // length high byte opens the checksum afresh
          len_hi_nxt = rx;
          xor_nxt    = rx;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- results
  always_comb begin
    res_vld    = 1'b0;
    res_byte   = '0;
    res_code   = FC_OK;
    res_status = '0;
    res_match  = 1'b0;
    res_kind   = KIND_DATA;
    res_last   = 1'b0;
    case (phase_r)
      PH_LEN_LO: begin
        if (len_bad) begin
          res_vld    = 1'b1;
          res_code   = FC_MALFORMED;
          res_status = STATUS_BAD;
          res_kind   = KIND_END;
          res_last   = 1'b1;
        end
      end
      PH_DATA: begin
        res_vld  = 1'b1;
        res_byte = rx;
      end
      PH_CHECK: begin
        res_vld   = 1'b1;
        res_kind  = KIND_END;
        res_last  = 1'b1;
        res_match = len_match;
        if (rx == xor_r) begin
          res_code   = FC_OK;
          res_status = status_r;
        end else begin
          res_code   = FC_CSUM_BAD;
          res_status = STATUS_BAD;
        end
      end
      default: res_vld = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEN_HI;
      len_hi_r  <= '0;
      len_m1_r  <= '0;
      left_r    <= '0;
      xor_r     <= '0;
      status_r  <= '0;
      exp_len_r <= EXP_LEN_RST;
      ov_r      <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      len_hi_r <= len_hi_nxt;
      len_m1_r <= len_m1_nxt;
      left_r   <= left_nxt;
      xor_r    <= xor_nxt;
      status_r <= status_nxt;
      if (cfg_valid && cfg_ready) begin
        exp_len_r <= cfg_data;
      end
      // load a fresh result, or drop the slot once drained
      if (in_acc) begin
        ov_r <= res_vld;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // output payload: hold while stalled, load on every accepted byte
  always_ff @(posedge clk) begin
    if (in_acc) begin
      o_byte_r   <= res_byte;
      o_code_r   <= res_code;
      o_status_r <= res_status;
      o_match_r  <= res_match;
      o_kind_r   <= res_kind;
      o_last_r   <= res_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, o_match_r, o_status_r, o_code_r, o_byte_r};
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;

  // ---------------------------------------------------------------- checks
  a_data_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (left_r != '0))
    else $error("data phase with no bytes left");

  a_check_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == PH_CHECK) |=> (ov_r && o_last_r && o_kind_r == KIND_END))
    else $error("checksum byte did not produce a verdict");

  a_status_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == PH_STATUS) |=> (phase_r == PH_CHECK && !ov_r))
    else $error("status byte misrouted");

  a_malformed_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_code_r == FC_MALFORMED) |-> (!o_match_r && o_status_r == STATUS_BAD))
    else $error("malformed verdict carries bad fields");

endmodule
